[hdl/ifl_pkg.sv]
// ----------------------------------------------------------------------------
// ifl_pkg
// Shared configuration type, constants and helper function of the inode fragment locator.
// ----------------------------------------------------------------------------
`default_nettype none

package ifl_pkg;

  localparam int unsigned DIV_W = 32;

  localparam logic [2:0] REG_LAYOUT_MODE      = 3'd0;
  localparam logic [2:0] REG_INODES_PER_GROUP = 3'd1;
  localparam logic [2:0] REG_FRAGS_PER_GROUP  = 3'd2;
  localparam logic [2:0] REG_INODE_AREA_START = 3'd3;
  localparam logic [2:0] REG_GROUP_STAGGER    = 3'd4;
  localparam logic [2:0] REG_STAGGER_MASK     = 3'd5;
  localparam logic [2:0] REG_BLOCK_SIZE_LOG2  = 3'd6;
  localparam logic [2:0] REG_FRAG_SIZE_LOG2   = 3'd7;

  localparam logic [1:0] LAYOUT_OLD_STAGGER = 2'd0;
  localparam logic [1:0] LAYOUT_NEW_PLAIN   = 2'd1;

  localparam logic [3:0] INODE_LOG2_SMALL = 4'd7;
  localparam logic [3:0] INODE_LOG2_LARGE = 4'd8;

  localparam logic [4:0] SIZE_LOG2_MIN = 5'd9;
  localparam logic [4:0] SIZE_LOG2_MAX = 5'd16;

  typedef struct packed {
    logic        use_stagger;
    logic [3:0]  ilog;
    logic [3:0]  ipb_log;
    logic [2:0]  fpb_log;
    logic [4:0]  flog;
    logic [15:0] frag_mask;
    logic [30:0] frags_per_group;
    logic [30:0] inode_area_start;
    logic [31:0] group_stagger;
    logic [31:0] stagger_mask;
  } ifl_cfg_t;

  function automatic logic [4:0] clamp_log2(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (v < SIZE_LOG2_MIN) begin
      r = SIZE_LOG2_MIN;
    end else if (v > SIZE_LOG2_MAX) begin
      r = SIZE_LOG2_MAX;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/inode_fragment_locator_top.sv]
// ----------------------------------------------------------------------------
// inode_fragment_locator_top
// Locates the fragment and byte offset of an inode record on disk.
// ----------------------------------------------------------------------------
// An inode number enters on the slave stream; one result leaves on the master
// stream for every input transaction, in order. The result data carries the
// fragment address in bits 63:0 and the byte offset in bits 79:64; tuser
// flags an error (inode zero or a zero group size), in which case both are 0.
// The block accepts one transaction per cycle while the receiver does not stall.
// A transaction passes 32 stages of the restoring divider, one bit of quotient
// each, then a multiply stage, an add stage and the output register. When the
// receiver stalls, the whole pipeline holds and the slave tready drops while
// the output register is full; nothing is lost or repeated. Reset empties the
// pipeline and loads the default geometry. The user must write configuration
// through the plain write port only while no transaction is in flight; the
// block does not enforce this. Derived settings take effect the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module inode_fragment_locator_top
  import ifl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // inode_number
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [79:0]      m_axis_tdata_o,   // fragment_address, offset_in_fragment
  output logic             m_axis_tuser_o    // error
);

  logic [1:0]  layout_mode_q;
  logic [31:0] inodes_per_group_q;
  logic [30:0] frags_per_group_q;
  logic [30:0] inode_area_start_q;
  logic [31:0] group_stagger_q;
  logic [31:0] stagger_mask_q;
  logic [4:0]  block_size_log2_q;
  logic [4:0]  frag_size_log2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_mode_q      <= LAYOUT_OLD_STAGGER;
      inodes_per_group_q <= 32'd2048;
      frags_per_group_q  <= 31'd16384;
      inode_area_start_q <= '0;
      group_stagger_q    <= '0;
      stagger_mask_q     <= '0;
      block_size_log2_q  <= 5'd13;
      frag_size_log2_q   <= 5'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LAYOUT_MODE:      layout_mode_q      <= cfg_data_i[1:0];
        REG_INODES_PER_GROUP: inodes_per_group_q <= cfg_data_i;
        REG_FRAGS_PER_GROUP:  frags_per_group_q  <= cfg_data_i[30:0];
        REG_INODE_AREA_START: inode_area_start_q <= cfg_data_i[30:0];
        REG_GROUP_STAGGER:    group_stagger_q    <= cfg_data_i;
        REG_STAGGER_MASK:     stagger_mask_q     <= cfg_data_i;
        REG_BLOCK_SIZE_LOG2:  block_size_log2_q  <= cfg_data_i[4:0];
        REG_FRAG_SIZE_LOG2:   frag_size_log2_q   <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic [4:0]  flog;
  logic [4:0]  blog;
  logic [3:0]  ilog;
  logic [16:0] fmask_full;
  ifl_cfg_t    cfg_d, cfg_q;

  always_comb begin
    flog = clamp_log2(frag_size_log2_q);
    blog = clamp_log2(block_size_log2_q);
    if (blog < flog) begin
      blog = flog;
    end
    ilog = (layout_mode_q == LAYOUT_OLD_STAGGER) ? INODE_LOG2_SMALL : INODE_LOG2_LARGE;
    fmask_full = (17'd1 << flog) - 17'd1;

    cfg_d.use_stagger      = (layout_mode_q != LAYOUT_NEW_PLAIN);
    cfg_d.ilog             = ilog;
    cfg_d.ipb_log          = 4'(blog - 5'(ilog));
    cfg_d.fpb_log          = 3'(blog - flog);
    cfg_d.flog             = flog;
    cfg_d.frag_mask        = fmask_full[15:0];
    cfg_d.frags_per_group  = frags_per_group_q;
    cfg_d.inode_area_start = inode_area_start_q;
    cfg_d.group_stagger    = group_stagger_q;
    cfg_d.stagger_mask     = stagger_mask_q;
  end

  always_ff @(posedge clk_i) begin
    cfg_q <= cfg_d;
  end

  logic en;
  logic in_err;

  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign in_err          = (s_axis_tdata_i == 32'd0) || (inodes_per_group_q == 32'd0)
                        || (frags_per_group_q == 31'd0);

  logic             div_vld;
  logic             div_err;
  logic [DIV_W-1:0] div_quot;
  logic [DIV_W-1:0] div_rem;

  ifl_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (s_axis_tvalid_i),
    .err_i       (in_err),
    .dividend_i  (s_axis_tdata_i),
    .divisor_i   (inodes_per_group_q),
    .valid_o     (div_vld),
    .err_o       (div_err),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  logic [63:0] addr;
  logic [15:0] offset;

  ifl_addr_calc u_addr_calc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .cfg_i      (cfg_q),
    .valid_i    (div_vld),
    .err_i      (div_err),
    .group_i    (div_quot),
    .in_group_i (div_rem),
    .valid_o    (m_axis_tvalid_o),
    .err_o      (m_axis_tuser_o),
    .addr_o     (addr),
    .offset_o   (offset)
  );

  assign m_axis_tdata_o = {offset, addr};

endmodule

`default_nettype wire

[hdl/ifl_divider.sv]
// ----------------------------------------------------------------------------
// ifl_divider
// Pipelined restoring divider: one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ifl_divider
  import ifl_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic             err_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [DIV_W-1:0] divisor_i,
  output logic                  valid_o,
  output logic                  err_o,
  output logic [DIV_W-1:0]      quotient_o,
  output logic [DIV_W-1:0]      remainder_o
);

  logic             vld_q [DIV_W];
  logic             err_q [DIV_W];
  logic [DIV_W-1:0] rem_q [DIV_W];
  logic [DIV_W-1:0] num_q [DIV_W];

  for (genvar k = 0; k < DIV_W; k++) begin : g_stage
    logic             vld_in;
    logic             err_in;
    logic [DIV_W-1:0] rem_in;
    logic [DIV_W-1:0] num_in;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      assign err_in = err_i;
      assign rem_in = '0;
      assign num_in = dividend_i;
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      assign err_in = err_q[k-1];
      assign rem_in = rem_q[k-1];
      assign num_in = num_q[k-1];
    end

    assign trial = {rem_in, num_in[DIV_W-1]};
    assign ge    = (trial >= {1'b0, divisor_i});
    assign diff  = trial - {1'b0, divisor_i};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        err_q[k] <= err_in;
        rem_q[k] <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        num_q[k] <= {num_in[DIV_W-2:0], ge};
      end
    end
  end

  assign valid_o     = vld_q[DIV_W-1];
  assign err_o       = err_q[DIV_W-1];
  assign quotient_o  = num_q[DIV_W-1];
  assign remainder_o = rem_q[DIV_W-1];

endmodule

`default_nettype wire

[hdl/ifl_addr_calc.sv]
// ----------------------------------------------------------------------------
// ifl_addr_calc
// Multiply and add stages that turn group and in-group index into the
// fragment address and byte offset; the last stage is the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ifl_addr_calc
  import ifl_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire ifl_cfg_t         cfg_i,
  input  wire logic             valid_i,
  input  wire logic             err_i,
  input  wire logic [DIV_W-1:0] group_i,
  input  wire logic [DIV_W-1:0] in_group_i,
  output logic                  valid_o,
  output logic                  err_o,
  output logic [63:0]           addr_o,
  output logic [15:0]           offset_o
);

  // Multiply stage.
  logic        m_vld_q;
  logic        m_err_q;
  logic [62:0] m_prod_f_q, m_prod_f_d;
  logic [63:0] m_prod_s_q, m_prod_s_d;
  logic [31:0] m_gm_q, m_gm_d;
  logic [38:0] m_frag_q, m_frag_d;
  logic [15:0] m_off_q, m_off_d;
  logic [31:0] low_bits;
  logic [31:0] rec_shift;
  logic [15:0] rec_byte;

  always_comb begin
    m_gm_d     = group_i & ~cfg_i.stagger_mask;
    m_prod_f_d = 63'(group_i) * 63'(cfg_i.frags_per_group);
    m_prod_s_d = 64'(m_gm_d) * 64'(cfg_i.group_stagger);
    low_bits   = in_group_i & ((32'd1 << cfg_i.ipb_log) - 32'd1);
    rec_shift  = low_bits << cfg_i.ilog;
    rec_byte   = rec_shift[15:0];
    m_frag_d   = (39'(in_group_i >> cfg_i.ipb_log) << cfg_i.fpb_log)
               | 39'(rec_byte >> cfg_i.flog);
    m_off_d    = rec_byte & cfg_i.frag_mask;
  end

  // First add stage.
  logic        a_vld_q;
  logic        a_err_q;
  logic [63:0] a_sum_q, a_sum_d;
  logic [39:0] a_part_q, a_part_d;
  logic [15:0] a_off_q;
  logic [63:0] stag;

  always_comb begin
    stag = {m_prod_s_q[63:32] - (cfg_i.group_stagger[31] ? m_gm_q : 32'd0),
            m_prod_s_q[31:0]};
    a_sum_d  = 64'(m_prod_f_q) + (cfg_i.use_stagger ? stag : 64'd0);
    a_part_d = 40'(cfg_i.inode_area_start) + 40'(m_frag_q);
  end

  // Output stage.
  logic        o_vld_q;
  logic        o_err_q;
  logic [63:0] o_addr_q, o_addr_d;
  logic [15:0] o_off_q, o_off_d;

  always_comb begin
    o_addr_d = a_err_q ? 64'd0 : (a_sum_q + 64'(a_part_q));
    o_off_d  = a_err_q ? 16'd0 : a_off_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
      a_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else if (en_i) begin
      m_vld_q <= valid_i;
      a_vld_q <= m_vld_q;
      o_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_err_q    <= err_i;
      m_prod_f_q <= m_prod_f_d;
      m_prod_s_q <= m_prod_s_d;
      m_gm_q     <= m_gm_d;
      m_frag_q   <= m_frag_d;
      m_off_q    <= m_off_d;
      a_err_q    <= m_err_q;
      a_sum_q    <= a_sum_d;
      a_part_q   <= a_part_d;
      a_off_q    <= m_off_q;
      o_err_q    <= a_err_q;
      o_addr_q   <= o_addr_d;
      o_off_q    <= o_off_d;
    end
  end

  assign valid_o  = o_vld_q;
  assign err_o    = o_err_q;
  assign addr_o   = o_addr_q;
  assign offset_o = o_off_q;

endmodule

`default_nettype wire

[hdl/ifl_chk.sv]
// ----------------------------------------------------------------------------
// ifl_chk
// Port-level assertions for the inode fragment locator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ifl_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [79:0] m_axis_tdata_o,
  input wire logic        m_axis_tuser_o
);

  // An error result carries neither an address nor an offset.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == 80'd0))
    else $error("error result with nonzero data");

  // Records are at least 128 bytes, so the offset is a multiple of 128.
  a_off_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[70:64] == 7'd0))
    else $error("misaligned offset");

  // With the output register empty the block always takes a transaction.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled result changed");

endmodule

bind inode_fragment_locator_top ifl_chk u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
